FILE: hdl/psct_pkg.sv
// ============================================================================
// psct_pkg
// Widths, Q16.16 constants and function codes for the parabolic sin/cos/tan
// pipeline.
// ============================================================================
`default_nettype none

package psct_pkg;

    // Input and output field widths
    localparam int FUNC_W  = 2;
    localparam int ANGLE_W = 16;
    localparam int VALUE_W = 32;

    // Fraction bits of Q16.16 and angle widening shift (Q4.12 -> Q16.16)
    localparam int FRAC_W  = 16;
    localparam int WIDEN_SH = 4;

    // Angle widths: widened raw angle plus headroom, and wrapped angle
    localparam int X_EXT_W = ANGLE_W + WIDEN_SH + 1;
    localparam int ANG_W   = 19;

    // Parabola datapath widths
    localparam int M_W  = 2 * ANG_W;        // x*|x|
    localparam int P_W  = M_W - FRAC_W;     // rounded x*|x|
    localparam int T_W  = 40;               // constant products
    localparam int Y_W  = 20;               // parabola value, |y| <= ~1.0
    localparam int YY_W = 2 * Y_W;          // y*|y|
    localparam int D_W  = YY_W - FRAC_W;    // q - y
    localparam int E_W  = 40;               // 0.225*(q - y)

    localparam int PAR_STAGES = 8;

    // Divider: |sin| << 16 over |cos|, restoring, three quotient bits per stage
    localparam int DIV_W      = Y_W + FRAC_W;
    localparam int DVS_W      = Y_W;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = DIV_W / DIV_STEPS;

    // Q16.16 constants
    localparam int Q_PI      = 205887;
    localparam int Q_TWO_PI  = 411775;
    localparam int Q_HALF_PI = 102944;
    localparam int Q_B       = 83443;   // 4/pi
    localparam int Q_C       = 26561;   // 4/pi^2
    localparam int Q_P       = 14746;   // 0.225
    localparam int Q_HALF    = 32768;

    // Clamp bounds for the tangent magnitude
    localparam longint POS_LIM = 64'sd2147483647;
    localparam longint NEG_LIM = 64'sd2147483648;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRAP = 2'd0,
        FUNC_SIN  = 2'd1,
        FUNC_COS  = 2'd2,
        FUNC_TAN  = 2'd3
    } psct_func_t;

endpackage

`default_nettype wire

FILE: hdl/parabolic_sine_cosine_tangent_top.sv
// ============================================================================
// parabolic_sine_cosine_tangent_top
// Angle wrap, parabolic sine/cosine and tangent in one pipeline.
// ============================================================================
//
// Takes one word per cycle (func, Q4.12 angle) while in_stall is low and
// returns one word (Q16.16 value, saturated flag) per input, in order.
// Every word runs the same 24-stage pipeline whatever its function code:
// 2 stages of angle wrap, 8 stages of parabola (sine and cosine in
// parallel), 1 divider setup stage, 12 divider stages (3 quotient bits
// each over a 36-bit |sin|<<16 dividend) and the output register. The
// sustained rate is one word per cycle while out_stall is low. Each stage
// holds its own valid bit and fills bubbles when out_stall is high, so
// in_stall rises only once every stage holds a word.
//
`default_nettype none

module parabolic_sine_cosine_tangent_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [psct_pkg::FUNC_W-1:0]            func,
    input  logic signed [psct_pkg::ANGLE_W-1:0]    angle,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [psct_pkg::VALUE_W-1:0]    value,
    output logic                                   saturated
);
    import psct_pkg::*;

    // Stage map
    localparam int ST_A      = 0;
    localparam int ST_B      = 1;
    localparam int PAR_FIRST = 2;
    localparam int ST_D0     = PAR_FIRST + PAR_STAGES;
    localparam int DIV_FIRST = ST_D0 + 1;
    localparam int ST_OUT    = DIV_FIRST + DIV_STAGES;
    localparam int NSTAGES   = ST_OUT + 1;

    // Words that ride beside the parabola and the divider
    typedef struct packed {
        psct_func_t              func;
        logic signed [ANG_W-1:0] x;
    } par_side_t;

    typedef struct packed {
        psct_func_t                func;
        logic                      neg;     // quotient sign
        logic                      czero;   // cosine is zero
        logic                      s_neg;   // sine is negative
        logic signed [VALUE_W-1:0] pass;    // result of the non-tangent modes
    } div_side_t;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------
    logic [NSTAGES-1:0] valid_reg, valid_next;
    logic [NSTAGES:0]   en;

    always_comb
    begin
        en[NSTAGES] = !out_stall;
        for (int i = NSTAGES - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < NSTAGES; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NSTAGES-1];

    // ------------------------------------------------------------------
    // Stage A: widen to Q16.16 and wrap into [-pi, pi]
    // Stage B: cosine argument, x + pi/2 wrapped once more
    // ------------------------------------------------------------------
    psct_func_t              a_func_reg, b_func_reg;
    logic signed [ANG_W-1:0] a_x_reg, b_x_reg, b_xc_reg;

    logic signed [X_EXT_W-1:0] x_wide, x_wrap, xc_sum, xc_wrap;
    logic signed [ANG_W-1:0]   a_x_next, b_xc_next;

    always_comb
    begin
        x_wide = X_EXT_W'(angle) <<< WIDEN_SH;
        if (x_wide > X_EXT_W'(Q_PI))
        begin
            x_wrap = x_wide - X_EXT_W'(Q_TWO_PI);
        end
        else if (x_wide < X_EXT_W'(-Q_PI))
        begin
            x_wrap = x_wide + X_EXT_W'(Q_TWO_PI);
        end
        else
        begin
            x_wrap = x_wide;
        end
        a_x_next = x_wrap[ANG_W-1:0];

        xc_sum = X_EXT_W'(a_x_reg) + X_EXT_W'(Q_HALF_PI);
        if (xc_sum > X_EXT_W'(Q_PI))
        begin
            xc_wrap = xc_sum - X_EXT_W'(Q_TWO_PI);
        end
        else
        begin
            xc_wrap = xc_sum;
        end
        b_xc_next = xc_wrap[ANG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_A])
        begin
            a_func_reg <= psct_func_t'(func);
            a_x_reg    <= a_x_next;
        end
        if (en[ST_B])
        begin
            b_func_reg <= a_func_reg;
            b_x_reg    <= a_x_reg;
            b_xc_reg   <= b_xc_next;
        end
    end

    // ------------------------------------------------------------------
    // Parabola: sine on x, cosine on the shifted argument
    // ------------------------------------------------------------------
    logic signed [Y_W-1:0] s_y, c_y;
    par_side_t             par_side_reg [PAR_STAGES];

    psct_parabola u_sin (
        .clk (clk),
        .en  (en[PAR_FIRST +: PAR_STAGES]),
        .x   (b_x_reg),
        .y   (s_y)
    );

    psct_parabola u_cos (
        .clk (clk),
        .en  (en[PAR_FIRST +: PAR_STAGES]),
        .x   (b_xc_reg),
        .y   (c_y)
    );

    always_ff @(posedge clk)
    begin
        if (en[PAR_FIRST])
        begin
            par_side_reg[0] <= '{func: b_func_reg, x: b_x_reg};
        end
        for (int k = 1; k < PAR_STAGES; k++)
        begin
            if (en[PAR_FIRST + k])
            begin
                par_side_reg[k] <= par_side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: magnitudes, signs, pass-through value
    // ------------------------------------------------------------------
    par_side_t        par_last;
    div_side_t        d0_side_next, d0_side_reg;
    logic [Y_W-1:0]   s_mag, c_mag;
    logic [DIV_W-1:0] d0_dividend_reg;
    logic [DVS_W-1:0] d0_divisor_reg;

    always_comb
    begin
        par_last = par_side_reg[PAR_STAGES-1];
        s_mag    = (s_y < 0) ? Y_W'(-s_y) : Y_W'(s_y);
        c_mag    = (c_y < 0) ? Y_W'(-c_y) : Y_W'(c_y);

        d0_side_next.func  = par_last.func;
        d0_side_next.s_neg = (s_y < 0);
        d0_side_next.neg   = (s_y < 0) ^ (c_y < 0);
        d0_side_next.czero = (c_y == '0);
        case (par_last.func)
            FUNC_WRAP: d0_side_next.pass = VALUE_W'(par_last.x);
            FUNC_SIN:  d0_side_next.pass = VALUE_W'(s_y);
            FUNC_COS:  d0_side_next.pass = VALUE_W'(c_y);
            default:   d0_side_next.pass = VALUE_W'(s_y);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_D0])
        begin
            d0_side_reg     <= d0_side_next;
            d0_dividend_reg <= {s_mag, {FRAC_W{1'b0}}};
            d0_divisor_reg  <= DVS_W'(c_mag);
        end
    end

    // ------------------------------------------------------------------
    // Divider and its side words
    // ------------------------------------------------------------------
    logic [DIV_W-1:0] quotient;
    div_side_t        div_side_reg [DIV_STAGES];

    psct_div u_div (
        .clk      (clk),
        .en       (en[DIV_FIRST +: DIV_STAGES]),
        .dividend (d0_dividend_reg),
        .divisor  (d0_divisor_reg),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (en[DIV_FIRST])
        begin
            div_side_reg[0] <= d0_side_reg;
        end
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (en[DIV_FIRST + k])
            begin
                div_side_reg[k] <= div_side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: sign the quotient, clamp, or pass the other modes through
    // ------------------------------------------------------------------
    div_side_t                 side_last;
    logic [DIV_W-1:0]          q_neg;
    logic signed [VALUE_W-1:0] value_next, value_reg;
    logic                      sat_next, saturated_reg;

    always_comb
    begin
        side_last = div_side_reg[DIV_STAGES-1];
        q_neg     = DIV_W'(0) - quotient;
        sat_next  = 1'b0;
        if (side_last.func != FUNC_TAN)
        begin
            value_next = side_last.pass;
        end
        else if (side_last.czero)
        begin
            sat_next   = 1'b1;
            value_next = side_last.s_neg ? VALUE_W'(-NEG_LIM) : VALUE_W'(POS_LIM);
        end
        else if (side_last.neg)
        begin
            if (quotient > DIV_W'(NEG_LIM))
            begin
                sat_next   = 1'b1;
                value_next = VALUE_W'(-NEG_LIM);
            end
            else
            begin
                value_next = q_neg[VALUE_W-1:0];
            end
        end
        else
        begin
            if (quotient > DIV_W'(POS_LIM))
            begin
                sat_next   = 1'b1;
                value_next = VALUE_W'(POS_LIM);
            end
            else
            begin
                value_next = quotient[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            value_reg     <= value_next;
            saturated_reg <= sat_next;
        end
    end

    assign value     = value_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

FILE: hdl/psct_parabola.sv
// ============================================================================
// psct_parabola
// Eight-stage pipelined parabolic sine with the 0.225 refinement.
// ============================================================================
`default_nettype none

module psct_parabola (
    input  logic                                 clk,
    input  logic [psct_pkg::PAR_STAGES-1:0]      en,
    input  logic signed [psct_pkg::ANG_W-1:0]    x,
    output logic signed [psct_pkg::Y_W-1:0]      y
);
    import psct_pkg::*;

    logic signed [ANG_W-1:0] x1_reg, x2_reg;
    logic signed [M_W-1:0]   m1_reg;
    logic signed [P_W-1:0]   p2_reg;
    logic signed [T_W-1:0]   t1_reg, t2_reg;
    logic signed [Y_W-1:0]   y4_reg, y5_reg, y6_reg, y7_reg, y8_reg;
    logic signed [YY_W-1:0]  yy5_reg;
    logic signed [D_W-1:0]   d6_reg;
    logic signed [E_W-1:0]   e7_reg;

    logic signed [ANG_W-1:0] ax;
    logic signed [M_W-1:0]   m_next, m_rnd;
    logic signed [P_W-1:0]   p_next;
    logic signed [T_W:0]     diff, diff_rnd;
    logic signed [Y_W-1:0]   y_next, ay4;
    logic signed [YY_W-1:0]  yy_rnd;
    logic signed [D_W-1:0]   q6, d_next;
    logic signed [E_W-1:0]   e_rnd;
    logic signed [Y_W-1:0]   corr, y8_next;

    always_comb
    begin
        // stage 1: x*|x|
        ax     = (x < 0) ? -x : x;
        m_next = M_W'(x) * M_W'(ax);
        // stage 2: round to Q16.16
        m_rnd  = (m1_reg + M_W'(Q_HALF)) >>> FRAC_W;
        p_next = m_rnd[P_W-1:0];
        // stage 4: sum of products, one rounding
        diff     = (T_W+1)'(t1_reg) - (T_W+1)'(t2_reg);
        diff_rnd = (diff + (T_W+1)'(Q_HALF)) >>> FRAC_W;
        y_next   = diff_rnd[Y_W-1:0];
        // stage 5 operand
        ay4 = (y4_reg < 0) ? -y4_reg : y4_reg;
        // stage 6: q - y
        yy_rnd = (yy5_reg + YY_W'(Q_HALF)) >>> FRAC_W;
        q6     = yy_rnd[D_W-1:0];
        d_next = q6 - D_W'(y5_reg);
        // stage 8: y + round(0.225*(q - y))
        e_rnd   = (e7_reg + E_W'(Q_HALF)) >>> FRAC_W;
        corr    = e_rnd[Y_W-1:0];
        y8_next = y7_reg + corr;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg <= x;
            m1_reg <= m_next;
        end
        if (en[1])
        begin
            x2_reg <= x1_reg;
            p2_reg <= p_next;
        end
        if (en[2])
        begin
            t1_reg <= T_W'(x2_reg) * T_W'(Q_B);
            t2_reg <= T_W'(p2_reg) * T_W'(Q_C);
        end
        if (en[3])
        begin
            y4_reg <= y_next;
        end
        if (en[4])
        begin
            y5_reg  <= y4_reg;
            yy5_reg <= YY_W'(y4_reg) * YY_W'(ay4);
        end
        if (en[5])
        begin
            y6_reg <= y5_reg;
            d6_reg <= d_next;
        end
        if (en[6])
        begin
            y7_reg <= y6_reg;
            e7_reg <= E_W'(d6_reg) * E_W'(Q_P);
        end
        if (en[7])
        begin
            y8_reg <= y8_next;
        end
    end

    assign y = y8_reg;

endmodule

`default_nettype wire

FILE: hdl/psct_div.sv
// ============================================================================
// psct_div
// Pipelined unsigned restoring divider, three quotient bits per stage.
// ============================================================================
`default_nettype none

module psct_div (
    input  logic                              clk,
    input  logic [psct_pkg::DIV_STAGES-1:0]   en,
    input  logic [psct_pkg::DIV_W-1:0]        dividend,
    input  logic [psct_pkg::DVS_W-1:0]        divisor,
    output logic [psct_pkg::DIV_W-1:0]        quotient
);
    import psct_pkg::*;

    // w holds the remaining dividend bits in its top and the quotient
    // bits shifted in at its bottom
    logic [DVS_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_W-1:0] w_reg   [DIV_STAGES];
    logic [DVS_W-1:0] d_reg   [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic [DVS_W-1:0] r_in, d_in, r_out;
        logic [DIV_W-1:0] w_in, w_out;

        if (g == 0)
        begin : g_first
            assign r_in = '0;
            assign w_in = dividend;
            assign d_in = divisor;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[g-1];
            assign w_in = w_reg[g-1];
            assign d_in = d_reg[g-1];
        end

        always_comb
        begin
            logic [DVS_W:0]   r2;
            logic [DVS_W-1:0] r;
            logic [DIV_W-1:0] w;
            r  = r_in;
            w  = w_in;
            r2 = '0;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                r2 = {r, w[DIV_W-1]};
                w  = {w[DIV_W-2:0], 1'b0};
                if (r2 >= {1'b0, d_in})
                begin
                    r2   = r2 - {1'b0, d_in};
                    w[0] = 1'b1;
                end
                r = r2[DVS_W-1:0];
            end
            r_out = r;
            w_out = w;
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                rem_reg[g] <= r_out;
                w_reg[g]   <= w_out;
                d_reg[g]   <= d_in;
            end
        end
    end

    assign quotient = w_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for parabolic_sine_cosine_tangent_top
// Drives function code / Q4.12 angle words through the valid/stall input
// channel and checks every Q16.16 result word against an in-bench fixed-point
// model of the wrap, parabolic sine/cosine and tangent datapath.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psct_pkg::*;

    // Q16.16 constants of the parabolic approximation
    localparam longint K_PI      = 205887;
    localparam longint K_TWO_PI  = 411775;
    localparam longint K_HALF_PI = 102944;
    localparam longint K_B       = 83443;     // 4/pi
    localparam longint K_C       = 26561;     // 4/pi^2
    localparam longint K_P       = 14746;     // 0.225
    localparam longint K_HALF    = 32768;
    localparam longint I32_MAX   = 64'sd2147483647;
    localparam longint I32_MIN   = -64'sd2147483648;

    localparam int N_RANDOM     = 1200;
    localparam int N_ROWS       = 22;
    localparam int IDLE_LIMIT   = 2000;      // cycles with no word moving
    localparam int TAIL_CYCLES  = 40;        // pipeline is 24 deep
    localparam int REPORT_MAX   = 10;
    localparam int POLE_BAND    = 200;       // |cos| below this counts as near a pole

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC, STALL_LONG}
        stall_mode_t;

    // One result word plus the input that caused it, for messages
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
        psct_func_t                func;
        logic signed [ANGLE_W-1:0] angle;
    } trig_word_t;

    // Directed row; known=1 means the expected word is written out here
    typedef struct packed {
        psct_func_t                func;
        logic signed [ANGLE_W-1:0] angle;
        logic                      known;
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    psct_func_t                func;
    logic signed [ANGLE_W-1:0] angle;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;

    // Expected word for the word currently offered, when the row types it in
    logic                      row_known;
    logic signed [VALUE_W-1:0] row_value;
    logic                      row_sat;

    trig_word_t                trig_expected[$];
    logic signed [ANGLE_W-1:0] pole_angles[$];
    logic signed [ANGLE_W-1:0] tan_special_angles[$];

    int failures;
    int results_checked;
    int func_seen[4];
    int clamp_seen;
    int burst_left;
    int idle_cycles;

    // Angle extremes, both edges of the +/-pi wrap, half-pi and zero.
    // Typed-in rows are pure wrap arithmetic or trivially zero.
    stim_row_t stim_rows [N_ROWS] = '{
        '{FUNC_WRAP, 16'sd0,       1'b1, 32'sd0,       1'b0},
        '{FUNC_WRAP, 16'sh7FFF,    1'b1, 32'sd112497,  1'b0},
        '{FUNC_WRAP, 16'sh8000,    1'b1, -32'sd112513, 1'b0},
        '{FUNC_WRAP, 16'sd12867,   1'b1, 32'sd205872,  1'b0},
        '{FUNC_WRAP, 16'sd12868,   1'b1, -32'sd205887, 1'b0},
        '{FUNC_WRAP, -16'sd12867,  1'b1, -32'sd205872, 1'b0},
        '{FUNC_WRAP, -16'sd12868,  1'b1, 32'sd205887,  1'b0},
        '{FUNC_SIN,  16'sd0,       1'b1, 32'sd0,       1'b0},
        '{FUNC_TAN,  16'sd0,       1'b1, 32'sd0,       1'b0},
        '{FUNC_COS,  16'sd0,       1'b0, 32'sd0,       1'b0},
        '{FUNC_SIN,  16'sd6434,    1'b0, 32'sd0,       1'b0},
        '{FUNC_SIN,  -16'sd6434,   1'b0, 32'sd0,       1'b0},
        '{FUNC_COS,  16'sd12868,   1'b0, 32'sd0,       1'b0},
        '{FUNC_COS,  16'sd12867,   1'b0, 32'sd0,       1'b0},
        '{FUNC_SIN,  16'sh7FFF,    1'b0, 32'sd0,       1'b0},
        '{FUNC_SIN,  16'sh8000,    1'b0, 32'sd0,       1'b0},
        '{FUNC_COS,  16'sh7FFF,    1'b0, 32'sd0,       1'b0},
        '{FUNC_COS,  16'sh8000,    1'b0, 32'sd0,       1'b0},
        '{FUNC_TAN,  16'sd6434,    1'b0, 32'sd0,       1'b0},
        '{FUNC_TAN,  -16'sd6434,   1'b0, 32'sd0,       1'b0},
        '{FUNC_TAN,  16'sh7FFF,    1'b0, 32'sd0,       1'b0},
        '{FUNC_TAN,  16'sh8000,    1'b0, 32'sd0,       1'b0}
    };

    parabolic_sine_cosine_tangent_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .saturated (saturated)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------------

    // Q32.32 product back to Q16.16: add half an LSB, floor (arithmetic shift)
    function automatic longint round_q16(input longint v);
        return (v + K_HALF) >>> FRAC_W;
    endfunction

    // 4/pi*x - 4/pi^2*x*|x|, then the 0.225 refinement
    function automatic longint parabola_q16(input longint x);
        longint p;
        longint y;
        longint q;
        p = round_q16(x * (x < 0 ? -x : x));
        y = round_q16(K_B * x - K_C * p);
        q = round_q16(y * (y < 0 ? -y : y));
        return y + round_q16(K_P * (q - y));
    endfunction

    function automatic trig_word_t predict_trig(input psct_func_t f,
                                                input logic signed [ANGLE_W-1:0] a);
        trig_word_t r;
        longint     x;
        longint     xc;
        longint     s;
        longint     c;
        longint     t;
        int         k;
        // Q4.12 -> Q16.16, then fold into [-pi, pi]; two folds cover +/-8 rad
        x = longint'(a) * 16;
        for (k = 0; k < 2; k++)
        begin
            if (x > K_PI)
                x = x - K_TWO_PI;
            else if (x < -K_PI)
                x = x + K_TWO_PI;
        end
        // cosine is the same curve a quarter turn on, folded once more
        xc = x + K_HALF_PI;
        if (xc > K_PI)
            xc = xc - K_TWO_PI;
        s = parabola_q16(x);
        c = parabola_q16(xc);
        r.func      = f;
        r.angle     = a;
        r.saturated = 1'b0;
        case (f)
            FUNC_WRAP: t = x;
            FUNC_SIN:  t = s;
            FUNC_COS:  t = c;
            default:
            begin
                if (c == 0)
                begin
                    // divide by zero: clamp by the sign of the sine
                    r.saturated = 1'b1;
                    t = (s >= 0) ? I32_MAX : I32_MIN;
                end
                else
                begin
                    t = (s * 65536) / c;   // truncates toward zero
                    if (t > I32_MAX)
                    begin
                        t = I32_MAX;
                        r.saturated = 1'b1;
                    end
                    else if (t < I32_MIN)
                    begin
                        t = I32_MIN;
                        r.saturated = 1'b1;
                    end
                end
            end
        endcase
        r.value = t[VALUE_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // Input accept pushes the expected word, output accept pops and compares.
    // Runs in the active region of the rising edge, so it sees pre-edge values.
    always @(posedge clk)
    begin
        trig_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (row_known)
                begin
                    want.value     = row_value;
                    want.saturated = row_sat;
                    want.func      = func;
                    want.angle     = angle;
                end
                else
                    want = predict_trig(func, angle);
                trig_expected.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (trig_expected.size() == 0)
                    note_failure($sformatf("unexpected word value=%0d saturated=%0b",
                                           value, saturated));
                else
                begin
                    want = trig_expected.pop_front();
                    func_seen[want.func]++;
                    if (want.saturated)
                        clamp_seen++;
                    if (value !== want.value || saturated !== want.saturated)
                        note_failure($sformatf(
                            "%s angle=%0d: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                            want.func.name(), want.angle, want.value, want.saturated,
                            value, saturated));
                end
            end
        end
    end

    // Watchdog: a hung handshake shows up as a long run of cycles where
    // neither channel moves a word.
    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("parabolic_sine_cosine_tangent_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: a randomly chosen stall pattern holds for a random span, including
    // stretches with no stall at all and long block stalls.
    // ------------------------------------------------------------------------
    initial
    begin
        stall_mode_t mode;
        int          span;
        int          k;
        out_stall = 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 4));
            span = $urandom_range(20, 160);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:     out_stall = 1'b0;
                    STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    out_stall = ($urandom_range(0, 9) < 7);
                    STALL_PERIODIC: out_stall = (k % 3 == 2);
                    default:        out_stall = (k < 30);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one word at the falling edge and hold it until accepted.
    // Bursts of random length, separated by random gaps.
    task automatic push_word(input psct_func_t f, input logic signed [ANGLE_W-1:0] a,
                             input logic known, input logic signed [VALUE_W-1:0] kv,
                             input logic ks);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid = 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid  = 1'b1;
        func      = f;
        angle     = a;
        row_known = known;
        row_value = kv;
        row_sat   = ks;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (trig_expected.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int                        n;
        int                        i;
        int                        ai;
        int                        pick;
        int                        sgn;
        int                        center;
        logic signed [ANGLE_W-1:0] ra;
        psct_func_t                rf;
        trig_word_t                cw;
        trig_word_t                tw;
        bit                        have_zero_cos;
        bit                        have_pos_clamp;
        bit                        have_neg_clamp;

        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        func            = FUNC_WRAP;
        angle           = '0;
        row_known       = 1'b0;
        row_value       = '0;
        row_sat         = 1'b0;
        failures        = 0;
        results_checked = 0;
        clamp_seen      = 0;
        burst_left      = 0;
        idle_cycles     = 0;
        have_zero_cos   = 1'b0;
        have_pos_clamp  = 1'b0;
        have_neg_clamp  = 1'b0;
        for (i = 0; i < 4; i++)
            func_seen[i] = 0;

        // Sweep every angle through the model (zero sim time) to find where
        // the cosine vanishes or gets small enough to clamp the tangent.
        for (ai = -32768; ai <= 32767; ai++)
        begin
            ra = ai[ANGLE_W-1:0];
            cw = predict_trig(FUNC_COS, ra);
            tw = predict_trig(FUNC_TAN, ra);
            if ((cw.value < 0 ? -cw.value : cw.value) < POLE_BAND)
                pole_angles.push_back(ra);
            if (cw.value == 0 && !have_zero_cos)
            begin
                have_zero_cos = 1'b1;
                tan_special_angles.push_back(ra);
            end
            else if (tw.saturated && tw.value > 0 && !have_pos_clamp)
            begin
                have_pos_clamp = 1'b1;
                tan_special_angles.push_back(ra);
            end
            else if (tw.saturated && tw.value < 0 && !have_neg_clamp)
            begin
                have_neg_clamp = 1'b1;
                tan_special_angles.push_back(ra);
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, then the tangent pole cases the sweep turned up
        for (i = 0; i < N_ROWS; i++)
            push_word(stim_rows[i].func, stim_rows[i].angle, stim_rows[i].known,
                      stim_rows[i].value, stim_rows[i].saturated);
        foreach (tan_special_angles[i])
            push_word(FUNC_TAN, tan_special_angles[i], 1'b0, '0, 1'b0);
        drain_results();

        // Random words: mostly uniform, the rest aimed at the wrap edges,
        // around zero and the half-pi points, and right at the tangent poles.
        for (n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            rf   = psct_func_t'($urandom_range(0, 3));
            sgn  = $urandom_range(0, 1) ? 1 : -1;
            if (pick < 55)
                ra = ANGLE_W'($urandom_range(0, 65535));
            else if (pick < 70 && pole_angles.size() > 0)
            begin
                rf = ($urandom_range(0, 3) == 0) ? FUNC_COS : FUNC_TAN;
                ra = pole_angles[$urandom_range(0, pole_angles.size() - 1)];
            end
            else if (pick < 85)
                ra = ANGLE_W'(sgn * 12868 + int'($urandom_range(0, 8)) - 4);
            else
            begin
                case ($urandom_range(0, 2))
                    0:       center = 0;
                    1:       center = 6434;
                    default: center = 19302;
                endcase
                ra = ANGLE_W'(sgn * center + int'($urandom_range(0, 64)) - 32);
            end
            push_word(rf, ra, 1'b0, '0, 1'b0);
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (trig_expected.size() != 0)
        begin
            note_failure($sformatf("%0d expected words never arrived", trig_expected.size()));
            failures = failures + trig_expected.size() - 1;
        end

        $display("Checked %0d words: wrap %0d, sine %0d, cosine %0d, tangent %0d.",
                 results_checked, func_seen[FUNC_WRAP], func_seen[FUNC_SIN],
                 func_seen[FUNC_COS], func_seen[FUNC_TAN]);
        $display("Tangent clamps %0d; zero-cosine angle %s; %0d angles near a pole.",
                 clamp_seen, have_zero_cos ? "hit" : "not reachable", pole_angles.size());
        if (failures == 0)
            $display("parabolic_sine_cosine_tangent_top verification clean");
        else
            $display("parabolic_sine_cosine_tangent_top verification failed");
        $finish;
    end

endmodule
